/* hdl/pwnr_pkg.sv */
// ----------------------------------------------------------------------------
// pwnr_pkg
// Shared constants and types for the pulse width nibble receiver.
// ----------------------------------------------------------------------------
package pwnr_pkg;

  localparam int unsigned NIBBLES_PER_FRAME = 16;
  localparam int unsigned BITS_PER_SYMBOL   = 4;

  localparam int unsigned CNT_W      = 8;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned NIB_IDX_W  = 4;
  localparam int unsigned BIT_IDX_W  = 2;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CNT_W-1:0] START_COUNT_RST   = 8'd186;
  localparam logic [CNT_W-1:0] ONE_THRESHOLD_RST = 8'd208;
  localparam logic [CNT_W-1:0] CNT_MAX           = 8'd255;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX  = BIT_IDX_W'(BITS_PER_SYMBOL - 1);
  localparam logic [NIB_IDX_W-1:0] LAST_NIB_IDX  = NIB_IDX_W'(NIBBLES_PER_FRAME - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_COUNT   = 1'b0,
    CFG_ONE_THRESHOLD = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    KIND_NIBBLE  = 1'b0,
    KIND_TIMEOUT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [NIB_W-1:0]     nibble;
    logic [NIB_IDX_W-1:0] nibble_index;
    logic                 frame_end;
    logic                 busy_res;
  } result_t;

endpackage

/* hdl/pulse_width_nibble_receiver_top.sv */
// ----------------------------------------------------------------------------
// pulse_width_nibble_receiver_top
// Decodes pulse widths on a sampled bus line into 4-bit nibbles per frame.
// Latency: a result is valid on the cycle after the input transfer.
// Throughput: one line sample per cycle; tready drops only while the result
// register is full and the master side stalls.
// Reset: all decode state clears, registers return to 186 / 208.
// ----------------------------------------------------------------------------
module pulse_width_nibble_receiver_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pwnr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pwnr_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // line samples
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [pwnr_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,  // [0] line_level
  // results
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [pwnr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,  // [3:0] nibble,
                                                              // [7:4] nibble_index,
                                                              // [8] busy_res
  output logic                               m_axis_tuser_o,  // [0] kind
  output logic                               m_axis_tlast_o   // frame_end
);

  logic [pwnr_pkg::CNT_W-1:0]     start_count_q, one_threshold_q;
  logic                           prev_level_q, prev_level_d;
  logic [pwnr_pkg::CNT_W-1:0]     count_q, count_d;
  logic                           counting_q, counting_d;
  logic [pwnr_pkg::NIB_W-1:0]     shift_q, shift_d;
  logic [pwnr_pkg::BIT_IDX_W-1:0] bit_idx_q, bit_idx_d;
  logic [pwnr_pkg::NIB_IDX_W-1:0] nib_cnt_q, nib_cnt_d;
  logic                           busy_q, busy_d;

  logic                           out_valid_q;
  pwnr_pkg::result_t              res_q, res_d;
  logic                           res_vld;

  logic in_xfer, level, rising, falling, timeout, bit_val;
  logic [pwnr_pkg::NIB_W-1:0] shifted;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign level   = s_axis_tdata_i[0];
  assign rising  = level && !prev_level_q;
  assign falling = !level && prev_level_q;
  assign timeout = counting_q && !rising && (count_q == pwnr_pkg::CNT_MAX);
  assign bit_val = count_q > one_threshold_q;
  assign shifted = {shift_q[pwnr_pkg::NIB_W-2:0], bit_val};

  always_comb begin
    prev_level_d = level;
    count_d      = count_q;
    counting_d   = counting_q;
    shift_d      = shift_q;
    bit_idx_d    = bit_idx_q;
    nib_cnt_d    = nib_cnt_q;
    busy_d       = busy_q;
    res_vld      = 1'b0;
    res_d        = '{kind: pwnr_pkg::KIND_NIBBLE, nibble: '0, nibble_index: '0,
                     frame_end: 1'b0, busy_res: 1'b0};
    if (timeout) begin
      count_d    = '0;
      counting_d = 1'b0;
      shift_d    = '0;
      bit_idx_d  = '0;
      nib_cnt_d  = '0;
      busy_d     = 1'b0;
      res_vld    = 1'b1;
      res_d      = '{kind: pwnr_pkg::KIND_TIMEOUT, nibble: '0, nibble_index: '0,
                     frame_end: 1'b1, busy_res: 1'b0};
    end else if (rising) begin
      busy_d     = 1'b1;
      count_d    = start_count_q;
      counting_d = 1'b1;
    end else begin
      if (falling) begin
        busy_d = 1'b1;
        if (bit_idx_q == pwnr_pkg::LAST_BIT_IDX) begin
          shift_d   = '0;
          bit_idx_d = '0;
          res_vld   = 1'b1;
          if (nib_cnt_q == pwnr_pkg::LAST_NIB_IDX) begin
            nib_cnt_d = '0;
            busy_d    = 1'b0;
          end else begin
            nib_cnt_d = nib_cnt_q + 1'b1;
          end
          res_d = '{kind: pwnr_pkg::KIND_NIBBLE, nibble: shifted,
                    nibble_index: nib_cnt_q,
                    frame_end: (nib_cnt_q == pwnr_pkg::LAST_NIB_IDX),
                    busy_res: busy_d};
        end else begin
          shift_d   = shifted;
          bit_idx_d = bit_idx_q + 1'b1;
        end
      end
      if (counting_q) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_count_q   <= pwnr_pkg::START_COUNT_RST;
      one_threshold_q <= pwnr_pkg::ONE_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      unique case (pwnr_pkg::cfg_idx_e'(cfg_index_i))
        pwnr_pkg::CFG_START_COUNT:   start_count_q   <= cfg_data_i;
        pwnr_pkg::CFG_ONE_THRESHOLD: one_threshold_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b0;
      count_q      <= '0;
      counting_q   <= 1'b0;
      shift_q      <= '0;
      bit_idx_q    <= '0;
      nib_cnt_q    <= '0;
      busy_q       <= 1'b0;
    end else if (in_xfer) begin
      prev_level_q <= prev_level_d;
      count_q      <= count_d;
      counting_q   <= counting_d;
      shift_q      <= shift_d;
      bit_idx_q    <= bit_idx_d;
      nib_cnt_q    <= nib_cnt_d;
      busy_q       <= busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer && res_vld) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && res_vld) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, res_q.busy_res, res_q.nibble_index, res_q.nibble};
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tlast_o  = res_q.frame_end;

  // timeout result carries no symbol and leaves the bus idle
  a_timeout_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == pwnr_pkg::KIND_TIMEOUT |->
      res_q.nibble == '0 && res_q.nibble_index == '0 && res_q.frame_end && !res_q.busy_res)
    else $error("timeout result fields wrong");

  a_frame_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_end |-> !res_q.busy_res)
    else $error("frame end with busy set");

  a_timeout_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && timeout |=> !counting_q && count_q == '0 && nib_cnt_q == '0 && !busy_q)
    else $error("timeout did not clear state");

  a_rise_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && rising |=> counting_q && busy_q && count_q == $past(start_count_q))
    else $error("rising edge did not start counter");

endmodule

/* test/tb_pulse_width_nibble_receiver_top.sv */
// ----------------------------------------------------------------------------
// tb_pulse_width_nibble_receiver_top
// Self-checking bench for the pulse width nibble receiver. Line samples are
// streamed in with random gaps. A cycle-accurate model of the edge detector,
// the duration counter and the nibble assembler predicts every nibble and
// timeout transfer not typed in the table. Results are drained with random
// back-pressure and one long stall. A short table of directed samples
// covers timeouts and the stopped-counter decode. Random pulse trains then
// run under several counter and threshold settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_pulse_width_nibble_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AT_RESULT = 25;
  localparam int PHASE_ITEMS    = 150;
  localparam int NUM_ROWS       = 27;

  typedef struct packed {
    logic              lvl;
    logic              typed;
    logic              has_res;
    pwnr_pkg::result_t res;
  } sample_row_t;

  localparam pwnr_pkg::result_t NO_RES  =
    '{pwnr_pkg::KIND_NIBBLE, 4'd0, 4'd0, 1'b0, 1'b0};
  localparam pwnr_pkg::result_t TMO_RES =
    '{pwnr_pkg::KIND_TIMEOUT, 4'd0, 4'd0, 1'b1, 1'b0};

  // start_count 250, one_threshold 252 for this table
  localparam sample_row_t DIR_ROWS [NUM_ROWS] = '{
    '{1'b0, 1'b1, 1'b0, NO_RES},   // idle line
    '{1'b1, 1'b1, 1'b0, NO_RES},   // rise
    '{1'b0, 1'b0, 1'b0, NO_RES},   // short pulse, bit 0
    '{1'b1, 1'b1, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, NO_RES},   // long pulse, bit 1
    '{1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b1, 1'b1, TMO_RES},  // wrap while low
    '{1'b1, 1'b1, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b1, 1'b1, TMO_RES},  // wrap while high
    '{1'b0, 1'b0, 1'b0, NO_RES},   // fall on stopped counter
    '{1'b1, 1'b1, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b1, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, 1'b1, 1'b0, NO_RES},
    '{1'b0, 1'b0, 1'b0, NO_RES}    // fourth bit, nibble out
  };

  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             cfg_valid_i     = 1'b0;
  logic                             cfg_ready_o;
  logic [pwnr_pkg::CFG_IDX_W-1:0]   cfg_index_i     = '0;
  logic [pwnr_pkg::CFG_DATA_W-1:0]  cfg_data_i      = '0;
  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [pwnr_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [pwnr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                             m_axis_tuser_o;
  logic                             m_axis_tlast_o;

  // decoder model state
  logic [pwnr_pkg::CNT_W-1:0]     cfg_start;
  logic [pwnr_pkg::CNT_W-1:0]     cfg_thresh;
  logic                           last_lvl;
  logic [pwnr_pkg::CNT_W-1:0]     dur_cnt;
  logic                           cnt_run;
  logic [pwnr_pkg::NIB_W-1:0]     nib_shift;
  logic [2:0]                     bit_pos;
  logic [pwnr_pkg::NIB_IDX_W-1:0] nib_cnt;
  logic                           line_busy;

  pwnr_pkg::result_t decoded_q [$];
  int      mismatches   = 0;
  int      results_seen = 0;
  int      idle_cycles  = 0;
  bit      tx_steady    = 1'b0;
  bit      rx_steady    = 1'b0;

  always #2 clk_i = ~clk_i;

  pulse_width_nibble_receiver_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  function automatic void reset_decoder();
    cfg_start  = pwnr_pkg::START_COUNT_RST;
    cfg_thresh = pwnr_pkg::ONE_THRESHOLD_RST;
    last_lvl   = 1'b0;
    dur_cnt    = '0;
    cnt_run    = 1'b0;
    nib_shift  = '0;
    bit_pos    = '0;
    nib_cnt    = '0;
    line_busy  = 1'b0;
  endfunction

  // one timer tick; returns 1 when a result is produced
  function automatic bit decode_tick(input logic lvl, output pwnr_pkg::result_t res);
    logic rise;
    logic fall;
    logic one;
    rise     = lvl && !last_lvl;
    fall     = !lvl && last_lvl;
    last_lvl = lvl;
    res      = NO_RES;
    decode_tick = 1'b0;
    if (cnt_run && !rise && dur_cnt == pwnr_pkg::CNT_MAX) begin
      dur_cnt   = '0;
      cnt_run   = 1'b0;
      nib_shift = '0;
      bit_pos   = '0;
      nib_cnt   = '0;
      line_busy = 1'b0;
      res       = TMO_RES;
      return 1'b1;
    end
    if (rise) begin
      line_busy = 1'b1;
      dur_cnt   = cfg_start;
      cnt_run   = 1'b1;
      return 1'b0;
    end
    if (fall) begin
      one       = dur_cnt > cfg_thresh;
      line_busy = 1'b1;
      nib_shift = {nib_shift[pwnr_pkg::NIB_W-2:0], one};
      bit_pos   = bit_pos + 3'd1;
      if (bit_pos == pwnr_pkg::BITS_PER_SYMBOL) begin
        res.kind         = pwnr_pkg::KIND_NIBBLE;
        res.nibble       = nib_shift;
        res.nibble_index = nib_cnt;
        bit_pos          = '0;
        nib_shift        = '0;
        if (nib_cnt == pwnr_pkg::LAST_NIB_IDX) begin
          res.frame_end = 1'b1;
          line_busy     = 1'b0;
        end
        nib_cnt      = nib_cnt + 1'b1;
        res.busy_res = line_busy;
        decode_tick  = 1'b1;
      end
    end
    if (cnt_run) dur_cnt = dur_cnt + 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic send_level(input logic lvl, input logic typed, input logic typed_has,
                            input pwnr_pkg::result_t typed_res);
    int                gap;
    bit                has;
    pwnr_pkg::result_t res;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(pwnr_pkg::IN_TDATA_W-1){1'b0}}, lvl};
    do @(posedge clk_i); while (!s_axis_tready_o);
    has = decode_tick(lvl, res);
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) decoded_q.push_back(res);
  endtask

  task automatic write_config(input logic [pwnr_pkg::CNT_W-1:0] start_v,
                              input logic [pwnr_pkg::CNT_W-1:0] thresh_v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= pwnr_pkg::CFG_START_COUNT;
    cfg_data_i  <= start_v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_start   = start_v;
    cfg_index_i <= pwnr_pkg::CFG_ONE_THRESHOLD;
    cfg_data_i  <= thresh_v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_thresh  = thresh_v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [pwnr_pkg::CNT_W-1:0] start_v,
                           input logic [pwnr_pkg::CNT_W-1:0] thresh_v);
    int span;
    int bnd;
    int pick;
    int hi;
    int lo;
    int n;
    int sent;
    drain();
    write_config(start_v, thresh_v);
    span = 256 - int'(start_v);
    bnd  = int'(thresh_v) - int'(start_v) + 1;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        n = $urandom_range(1, 6);
        repeat (n) send_level(1'($urandom_range(0, 1)), 1'b0, 1'b0, NO_RES);
        sent += n;
      end else if (pick < 13 && span <= 40) begin
        // pulse then a low stretch long enough to wrap the counter
        n = span + $urandom_range(1, 3);
        send_level(1'b1, 1'b0, 1'b0, NO_RES);
        repeat (n) send_level(1'b0, 1'b0, 1'b0, NO_RES);
        sent += n + 1;
      end else begin
        if ($urandom_range(0, 1) == 1 && bnd >= 1 && bnd <= 64)
          hi = bnd - 1 + $urandom_range(0, 2);
        else
          hi = $urandom_range(1, 24);
        if (hi > span - 1) hi = span - 1;
        if (hi < 1) hi = 1;
        lo = span - hi;
        if (lo > 8) lo = 8;
        if (lo < 1) lo = 1;
        lo = $urandom_range(1, lo);
        repeat (hi) send_level(1'b1, 1'b0, 1'b0, NO_RES);
        repeat (lo) send_level(1'b0, 1'b0, 1'b0, NO_RES);
        sent += hi + lo;
      end
    end
  endtask

  // result sink
  initial begin
    int                hold;
    pwnr_pkg::result_t exp_r;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      hold = rx_steady ? 0 : $urandom_range(0, 11);
      if (results_seen == HOLD_AT_RESULT) hold = LONG_HOLD;
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      results_seen++;
      if (decoded_q.size() == 0) begin
        $error("result with nothing pending: tdata 0x%0h tuser %0d tlast %0d",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        exp_r = decoded_q.pop_front();
        check_field("kind", exp_r.kind, m_axis_tuser_o);
        check_field("nibble", exp_r.nibble, m_axis_tdata_o[3:0]);
        check_field("nibble_index", exp_r.nibble_index, m_axis_tdata_o[7:4]);
        check_field("frame_end", exp_r.frame_end, m_axis_tlast_o);
        check_field("busy_res", exp_r.busy_res, m_axis_tdata_o[8]);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    reset_decoder();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_config(8'd250, 8'd252);
    for (int i = 0; i < NUM_ROWS; i++)
      send_level(DIR_ROWS[i].lvl, DIR_ROWS[i].typed, DIR_ROWS[i].has_res, DIR_ROWS[i].res);
    run_phase(8'd250, 8'd252);
    run_phase(8'd255, 8'd0);
    run_phase(8'd0, 8'd255);
    run_phase(8'd240, 8'd247);
    run_phase(8'd246, 8'd250);
    run_phase(8'd0, 8'd0);
    run_phase(8'd252, 8'd253);
    run_phase(pwnr_pkg::START_COUNT_RST, pwnr_pkg::ONE_THRESHOLD_RST);
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* pulse_width_nibble_receiver_top.f */
hdl/pwnr_pkg.sv
hdl/pulse_width_nibble_receiver_top.sv
test/tb_pulse_width_nibble_receiver_top.sv
